// ----- hw/rtl/sukl_pkg.sv -----
// Shared types and constants for the sorted unique key list.
// Request/response payloads, per-cell control, status codes, sequencer states.
// No dependencies.
`default_nettype none

package sukl_pkg;

  localparam int KEY_W          = 32;
  localparam int COUNT_OUT_W    = 7;
  localparam int CAPACITY_DFLT  = 64;

  typedef logic signed [KEY_W-1:0] key_t;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  typedef enum logic [2:0] {
    ST_DONE     = 3'd0,
    ST_DUP      = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef struct packed {
    logic opcode;
    key_t key;
  } sukl_req_t;

  typedef struct packed {
    logic [2:0]             status;
    logic [COUNT_OUT_W-1:0] entry_count;
  } sukl_rsp_t;

  typedef struct packed {
    logic cmp_en;
    logic ins_en;
    logic del_en;
  } sukl_cell_ctl_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_CMP,
    SEQ_UPD
  } sukl_state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sukl_cell.sv -----
// One slot of the key chain: holds a key and its valid bit, compares against
// the request key, and shifts from its left or right neighbor on update.
// Depends on sukl_pkg.
`default_nettype none

module sukl_cell (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire sukl_pkg::sukl_cell_ctl_t ctl,
  input  wire sukl_pkg::key_t          req_key,
  input  wire sukl_pkg::key_t          left_key,
  input  wire logic                    left_valid,
  input  wire logic                    left_lt,
  input  wire sukl_pkg::key_t          right_key,
  input  wire logic                    right_valid,
  output sukl_pkg::key_t               key,
  output logic                         valid,
  output logic                         lt,
  output logic                         eq
);
  import sukl_pkg::*;

  key_t key_r, key_nxt;
  logic valid_r, valid_nxt;
  logic lt_r, lt_nxt;
  logic eq_r, eq_nxt;

  always_comb begin
    lt_nxt = lt_r;
    eq_nxt = eq_r;
    if (ctl.cmp_en) begin
      lt_nxt = valid_r && (key_r < req_key);
      eq_nxt = valid_r && (key_r == req_key);
    end
  end

  // insert: slots at or above the position take the left neighbor (or the new key)
  // delete: slots at or above the position take the right neighbor
  always_comb begin
    key_nxt   = key_r;
    valid_nxt = valid_r;
    if (ctl.ins_en && !lt_r) begin
      if (left_lt) begin
        key_nxt   = req_key;
        valid_nxt = 1'b1;
      end else begin
        key_nxt   = left_key;
        valid_nxt = left_valid;
      end
    end else if (ctl.del_en && !lt_r) begin
      key_nxt   = right_key;
      valid_nxt = right_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      lt_r    <= 1'b0;
      eq_r    <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      lt_r    <= lt_nxt;
      eq_r    <= eq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign key   = key_r;
  assign valid = valid_r;
  assign lt    = lt_r;
  assign eq    = eq_r;

endmodule

`default_nettype wire

// ----- hw/rtl/sorted_unique_key_list_core.sv -----
// Top level of the sorted unique key list: request sequencer, count and a
// chain of CAPACITY sukl_cell slots. Depends on sukl_pkg and sukl_cell.
//
// Usage:
//   in_valid/in_ready carry one request (opcode: insert or delete, signed key).
//   out_valid/out_ready carry one response per request: status and the
//   number of keys held after that request.
//   Each request passes through the sequencer states in turn: idle accepts it,
//   in compare every cell compares its key against the request key, and in
//   update the cells at or above the position shift from a neighbor (only for
//   a request that changes the list) and the response is registered. A new
//   request is taken only after the previous one has left the update step.
//   The response sits in an output register; a new request is accepted while
//   it waits. If the receiver stalls, the next request holds in the update
//   step until the output register frees, and in_ready stays low meanwhile.
//   Reset (rst_n low, synchronous) empties the list and drops any pending
//   response; stored keys need no clearing since invalid slots are never read.
//   Duplicate inserts, inserts into a full list, deletes of absent keys and
//   deletes from an empty list leave the list unchanged.
`default_nettype none

module sorted_unique_key_list_core #(
  parameter int CAPACITY = sukl_pkg::CAPACITY_DFLT
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire sukl_pkg::sukl_req_t in_req,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output sukl_pkg::sukl_rsp_t      out_rsp
);
  import sukl_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  sukl_state_t state_r, state_nxt;
  sukl_req_t   req_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic        out_valid_r;
  sukl_rsp_t   out_r;

  logic           cmp_en;
  logic           upd_st;
  logic           upd_go;
  sukl_cell_ctl_t ctl;

  key_t            key_w   [CAPACITY];
  logic [CAPACITY-1:0] valid_w;
  logic [CAPACITY-1:0] lt_w;
  logic [CAPACITY-1:0] eq_w;

  logic        any_eq, is_full, is_empty, is_ins, apply;
  status_t     status;
  logic [CNT_W+COUNT_OUT_W-1:0] cnt_ext;
  logic [CNT_W+COUNT_OUT_W-1:0] cnt_r_ext;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      SEQ_IDLE: if (in_valid) state_nxt = SEQ_CMP;
      SEQ_CMP:  state_nxt = SEQ_UPD;
      SEQ_UPD:  if (!out_valid_r || out_ready) state_nxt = SEQ_IDLE;
      default:  state_nxt = SEQ_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmp_en   = 1'b0;
    upd_st   = 1'b0;
    case (state_r)
      SEQ_IDLE: in_ready = 1'b1;
      SEQ_CMP:  cmp_en   = 1'b1;
      SEQ_UPD:  upd_st   = 1'b1;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign upd_go = upd_st && (!out_valid_r || out_ready);

  // status decode
  assign any_eq   = |eq_w;
  assign is_full  = (count_r == CNT_W'(CAPACITY));
  assign is_empty = (count_r == '0);
  assign is_ins   = (req_r.opcode == OP_INSERT);

  always_comb begin
    if (is_ins) begin
      if (any_eq)       status = ST_DUP;
      else if (is_full) status = ST_FULL;
      else              status = ST_DONE;
    end else begin
      if (is_empty)     status = ST_EMPTY;
      else if (!any_eq) status = ST_NOTFOUND;
      else              status = ST_DONE;
    end
  end

  assign apply = (status == ST_DONE);

  always_comb begin
    count_nxt = count_r;
    if (upd_go && apply) begin
      if (is_ins) count_nxt = count_r + CNT_W'(1);
      else        count_nxt = count_r - CNT_W'(1);
    end
  end

  assign ctl.cmp_en = cmp_en;
  assign ctl.ins_en = upd_go && apply && is_ins;
  assign ctl.del_en = upd_go && apply && !is_ins;

  assign cnt_ext   = {{COUNT_OUT_W{1'b0}}, count_nxt};
  assign cnt_r_ext = {{COUNT_OUT_W{1'b0}}, count_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SEQ_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (upd_go)         out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) req_r <= in_req;
    if (upd_go) begin
      out_r.status      <= status;
      out_r.entry_count <= cnt_ext[COUNT_OUT_W-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_r;

  // cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    key_t l_key, r_key;
    logic l_valid, l_lt, r_valid;

    if (i == 0) begin : g_head
      assign l_key   = req_r.key;
      assign l_valid = 1'b1;
      assign l_lt    = 1'b1;
    end else begin : g_body
      assign l_key   = key_w[i-1];
      assign l_valid = valid_w[i-1];
      assign l_lt    = lt_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign r_key   = req_r.key;
      assign r_valid = 1'b0;
    end else begin : g_inner
      assign r_key   = key_w[i+1];
      assign r_valid = valid_w[i+1];
    end

    sukl_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .req_key     (req_r.key),
      .left_key    (l_key),
      .left_valid  (l_valid),
      .left_lt     (l_lt),
      .right_key   (r_key),
      .right_valid (r_valid),
      .key         (key_w[i]),
      .valid       (valid_w[i]),
      .lt          (lt_w[i]),
      .eq          (eq_w[i])
    );
  end

`ifndef SYNTHESIS
  a_upd_resp: assert property (@(posedge clk) disable iff (!rst_n)
    upd_go |=> out_valid_r)
    else $error("update step did not produce a response");

  a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
    valid_w[0] == (count_r != '0))
    else $error("head slot valid disagrees with count");

  a_tail_valid: assert property (@(posedge clk) disable iff (!rst_n)
    valid_w[CAPACITY-1] == (count_r == CNT_W'(CAPACITY)))
    else $error("tail slot valid disagrees with count");

  a_resp_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.entry_count == cnt_r_ext[COUNT_OUT_W-1:0]))
    else $error("pending response count disagrees with held count");
`endif

endmodule

`default_nettype wire
